FILE: src/cmfs_pkg.sv
package cmfs_pkg;

    localparam int CMFS_COMP_BITS = 16;
    localparam int CMFS_UV_BITS   = 16;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    // Side information that rides along with the divider lanes.
    typedef struct packed {
        face_t face;
        logic  sat_u;
        logic  sat_v;
        logic  degenerate;
    } cmfs_ctrl_t;

endpackage

FILE: src/cmfs_select.sv
module cmfs_select import cmfs_pkg::*; #(
    parameter int COMP_BITS = CMFS_COMP_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [COMP_BITS-1:0] dir_x,
    input  logic signed [COMP_BITS-1:0] dir_y,
    input  logic signed [COMP_BITS-1:0] dir_z,
    output logic                        out_valid,
    output face_t                       face,
    output logic        [COMP_BITS-1:0] ma,
    output logic signed [COMP_BITS-1:0] x_out,
    output logic signed [COMP_BITS-1:0] y_out,
    output logic signed [COMP_BITS-1:0] z_out
);

    logic [COMP_BITS-1:0] ux, uy, uz;
    logic [COMP_BITS-1:0] ax, ay, az;
    logic                 x_pos, y_pos, z_pos;
    face_t                face_next;
    logic [COMP_BITS-1:0] ma_next;

    logic                        valid_reg;
    face_t                       face_reg;
    logic        [COMP_BITS-1:0] ma_reg;
    logic signed [COMP_BITS-1:0] x_reg, y_reg, z_reg;

    assign ux = dir_x;
    assign uy = dir_y;
    assign uz = dir_z;

    // The most negative value maps to 2^(COMP_BITS-1), which still fits unsigned.
    assign ax = ux[COMP_BITS-1] ? (~ux + 1'b1) : ux;
    assign ay = uy[COMP_BITS-1] ? (~uy + 1'b1) : uy;
    assign az = uz[COMP_BITS-1] ? (~uz + 1'b1) : uz;

    assign x_pos = !ux[COMP_BITS-1] && (ux != '0);
    assign y_pos = !uy[COMP_BITS-1] && (uy != '0);
    assign z_pos = !uz[COMP_BITS-1] && (uz != '0);

    // Strict compares, so ties go to Y and then to Z.
    always_comb begin
        if (ax > ay && ax > az) begin
            ma_next   = ax;
            face_next = x_pos ? FACE_POS_X : FACE_NEG_X;
        end else if (ay > az) begin
            ma_next   = ay;
            face_next = y_pos ? FACE_POS_Y : FACE_NEG_Y;
        end else begin
            ma_next   = az;
            face_next = z_pos ? FACE_POS_Z : FACE_NEG_Z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            face_reg <= face_next;
            ma_reg   <= ma_next;
            x_reg    <= dir_x;
            y_reg    <= dir_y;
            z_reg    <= dir_z;
        end
    end

    assign out_valid = valid_reg;
    assign face      = face_reg;
    assign ma        = ma_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule

FILE: src/cmfs_prep.sv
module cmfs_prep import cmfs_pkg::*; #(
    parameter int COMP_BITS = CMFS_COMP_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  face_t                       face,
    input  logic        [COMP_BITS-1:0] ma,
    input  logic signed [COMP_BITS-1:0] x_in,
    input  logic signed [COMP_BITS-1:0] y_in,
    input  logic signed [COMP_BITS-1:0] z_in,
    output logic                        out_valid,
    output logic        [COMP_BITS:0]   rem_u,
    output logic        [COMP_BITS:0]   rem_v,
    output logic        [COMP_BITS:0]   divisor,
    output cmfs_ctrl_t                  ctrl
);

    logic [COMP_BITS:0]   xe, ye, ze, xn, yn, zn;
    logic [COMP_BITS:0]   sc, tc;
    logic [COMP_BITS+1:0] sum_u, sum_v, ma_ext;
    logic [COMP_BITS:0]   n_u, n_v, d_next;
    cmfs_ctrl_t           ctrl_next;

    logic                 valid_reg;
    logic [COMP_BITS:0]   rem_u_reg, rem_v_reg, divisor_reg;
    cmfs_ctrl_t           ctrl_reg;

    assign xe = {x_in[COMP_BITS-1], x_in};
    assign ye = {y_in[COMP_BITS-1], y_in};
    assign ze = {z_in[COMP_BITS-1], z_in};
    assign xn = ~xe + 1'b1;
    assign yn = ~ye + 1'b1;
    assign zn = ~ze + 1'b1;

    always_comb begin
        unique case (face)
            FACE_POS_X: begin sc = zn; tc = yn; end
            FACE_NEG_X: begin sc = ze; tc = yn; end
            FACE_POS_Y: begin sc = xe; tc = ze; end
            FACE_NEG_Y: begin sc = xe; tc = zn; end
            FACE_POS_Z: begin sc = xe; tc = yn; end
            FACE_NEG_Z: begin sc = xn; tc = yn; end
            default:    begin sc = xn; tc = yn; end
        endcase
    end

    // Since ma is the largest magnitude, c + ma lies in [0, 2*ma].
    assign ma_ext = {2'b00, ma};
    assign sum_u  = {sc[COMP_BITS], sc} + ma_ext;
    assign sum_v  = {tc[COMP_BITS], tc} + ma_ext;
    assign n_u    = sum_u[COMP_BITS:0];
    assign n_v    = sum_v[COMP_BITS:0];
    assign d_next = {ma, 1'b0};

    always_comb begin
        ctrl_next.face       = face;
        ctrl_next.sat_u      = (n_u == d_next);
        ctrl_next.sat_v      = (n_v == d_next);
        ctrl_next.degenerate = (ma == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // A saturated lane starts from zero so its remainder stays below the divisor.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_u_reg   <= ctrl_next.sat_u ? '0 : n_u;
            rem_v_reg   <= ctrl_next.sat_v ? '0 : n_v;
            divisor_reg <= d_next;
            ctrl_reg    <= ctrl_next;
        end
    end

    assign out_valid = valid_reg;
    assign rem_u     = rem_u_reg;
    assign rem_v     = rem_v_reg;
    assign divisor   = divisor_reg;
    assign ctrl      = ctrl_reg;

endmodule

FILE: src/cmfs_div_step.sv
module cmfs_div_step import cmfs_pkg::*; #(
    parameter int COMP_BITS = CMFS_COMP_BITS,
    parameter int UV_BITS   = CMFS_UV_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [COMP_BITS:0]   rem_u_in,
    input  logic [COMP_BITS:0]   rem_v_in,
    input  logic [UV_BITS-1:0]   q_u_in,
    input  logic [UV_BITS-1:0]   q_v_in,
    input  logic [COMP_BITS:0]   divisor_in,
    input  cmfs_ctrl_t           ctrl_in,
    output logic                 out_valid,
    output logic [COMP_BITS:0]   rem_u_out,
    output logic [COMP_BITS:0]   rem_v_out,
    output logic [UV_BITS-1:0]   q_u_out,
    output logic [UV_BITS-1:0]   q_v_out,
    output logic [COMP_BITS:0]   divisor_out,
    output cmfs_ctrl_t           ctrl_out
);

    logic [COMP_BITS+1:0] shift_u, shift_v, dd, diff_u, diff_v;
    logic                 ge_u, ge_v;

    logic                 valid_reg;
    logic [COMP_BITS:0]   rem_u_reg, rem_v_reg, divisor_reg;
    logic [UV_BITS-1:0]   q_u_reg, q_v_reg;
    cmfs_ctrl_t           ctrl_reg;

    // One restoring division step per lane: shift in a zero, try to subtract.
    assign shift_u = {rem_u_in, 1'b0};
    assign shift_v = {rem_v_in, 1'b0};
    assign dd      = {1'b0, divisor_in};
    assign ge_u    = (shift_u >= dd);
    assign ge_v    = (shift_v >= dd);
    assign diff_u  = shift_u - dd;
    assign diff_v  = shift_v - dd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_u_reg   <= ge_u ? diff_u[COMP_BITS:0] : shift_u[COMP_BITS:0];
            rem_v_reg   <= ge_v ? diff_v[COMP_BITS:0] : shift_v[COMP_BITS:0];
            q_u_reg     <= {q_u_in[UV_BITS-2:0], ge_u};
            q_v_reg     <= {q_v_in[UV_BITS-2:0], ge_v};
            divisor_reg <= divisor_in;
            ctrl_reg    <= ctrl_in;
        end
    end

    assign out_valid   = valid_reg;
    assign rem_u_out   = rem_u_reg;
    assign rem_v_out   = rem_v_reg;
    assign q_u_out     = q_u_reg;
    assign q_v_out     = q_v_reg;
    assign divisor_out = divisor_reg;
    assign ctrl_out    = ctrl_reg;

endmodule

FILE: src/cube_map_face_select_unit.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_dir_x, s_dir_y, s_dir_z
// m_        out        m_valid / m_ready   m_face_index, m_u_coord, m_v_coord, m_degenerate
//
// Stages in order: face select, operand prep, one quotient bit per divider stage,
// and the output register. One item can enter every cycle while s_ready is high.
// Reset (aresetn low at a clock edge) clears every stage valid bit.
// A stage loads whenever it is empty or the stage after it loads, so a stall
// at m_ready fills the bubbles first and then holds every item in place.
module cube_map_face_select_unit import cmfs_pkg::*; #(
    parameter int COMP_BITS = CMFS_COMP_BITS,
    parameter int UV_BITS   = CMFS_UV_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COMP_BITS-1:0] s_dir_x,
    input  logic signed [COMP_BITS-1:0] s_dir_y,
    input  logic signed [COMP_BITS-1:0] s_dir_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_face_index,
    output logic [UV_BITS-1:0]          m_u_coord,
    output logic [UV_BITS-1:0]          m_v_coord,
    output logic                        m_degenerate
);

    logic                        sel_valid, sel_en;
    face_t                       sel_face;
    logic        [COMP_BITS-1:0] sel_ma;
    logic signed [COMP_BITS-1:0] sel_x, sel_y, sel_z;

    // Index 0 is the prep stage output, index k+1 the output of divider step k.
    logic               div_valid [0:UV_BITS];
    logic               div_en    [0:UV_BITS];
    logic [COMP_BITS:0] div_rem_u [0:UV_BITS];
    logic [COMP_BITS:0] div_rem_v [0:UV_BITS];
    logic [UV_BITS-1:0] div_q_u   [0:UV_BITS];
    logic [UV_BITS-1:0] div_q_v   [0:UV_BITS];
    logic [COMP_BITS:0] div_d     [0:UV_BITS];
    cmfs_ctrl_t         div_ctrl  [0:UV_BITS];

    logic               out_en;
    logic               m_valid_reg;
    logic [2:0]         m_face_reg;
    logic [UV_BITS-1:0] m_u_reg, m_v_reg, m_u_next, m_v_next;
    logic               m_deg_reg;
    cmfs_ctrl_t         last_ctrl;

    assign out_en  = !m_valid_reg || m_ready;
    assign sel_en  = !sel_valid || div_en[0];
    assign s_ready = sel_en;

    assign div_en[UV_BITS] = !div_valid[UV_BITS] || out_en;

    cmfs_select #(.COMP_BITS(COMP_BITS)) u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (sel_en),
        .in_valid  (s_valid),
        .dir_x     (s_dir_x),
        .dir_y     (s_dir_y),
        .dir_z     (s_dir_z),
        .out_valid (sel_valid),
        .face      (sel_face),
        .ma        (sel_ma),
        .x_out     (sel_x),
        .y_out     (sel_y),
        .z_out     (sel_z)
    );

    cmfs_prep #(.COMP_BITS(COMP_BITS)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (div_en[0]),
        .in_valid  (sel_valid),
        .face      (sel_face),
        .ma        (sel_ma),
        .x_in      (sel_x),
        .y_in      (sel_y),
        .z_in      (sel_z),
        .out_valid (div_valid[0]),
        .rem_u     (div_rem_u[0]),
        .rem_v     (div_rem_v[0]),
        .divisor   (div_d[0]),
        .ctrl      (div_ctrl[0])
    );

    assign div_q_u[0] = '0;
    assign div_q_v[0] = '0;

    for (genvar k = 0; k < UV_BITS; k++) begin : g_div
        assign div_en[k] = !div_valid[k] || div_en[k+1];

        cmfs_div_step #(.COMP_BITS(COMP_BITS), .UV_BITS(UV_BITS)) u_step (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (div_en[k+1]),
            .in_valid    (div_valid[k]),
            .rem_u_in    (div_rem_u[k]),
            .rem_v_in    (div_rem_v[k]),
            .q_u_in      (div_q_u[k]),
            .q_v_in      (div_q_v[k]),
            .divisor_in  (div_d[k]),
            .ctrl_in     (div_ctrl[k]),
            .out_valid   (div_valid[k+1]),
            .rem_u_out   (div_rem_u[k+1]),
            .rem_v_out   (div_rem_v[k+1]),
            .q_u_out     (div_q_u[k+1]),
            .q_v_out     (div_q_v[k+1]),
            .divisor_out (div_d[k+1]),
            .ctrl_out    (div_ctrl[k+1])
        );
    end

    // The final remainders are not needed past the last step.
    assign last_ctrl = div_ctrl[UV_BITS];

    always_comb begin
        if (last_ctrl.degenerate) begin
            m_u_next = '0;
            m_v_next = '0;
        end else begin
            m_u_next = last_ctrl.sat_u ? '1 : div_q_u[UV_BITS];
            m_v_next = last_ctrl.sat_v ? '1 : div_q_v[UV_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= div_valid[UV_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_face_reg <= last_ctrl.face;
            m_u_reg    <= m_u_next;
            m_v_reg    <= m_v_next;
            m_deg_reg  <= last_ctrl.degenerate;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_face_index = m_face_reg;
    assign m_u_coord    = m_u_reg;
    assign m_v_coord    = m_v_reg;
    assign m_degenerate = m_deg_reg;

endmodule

FILE: src/cmfs_checker.sv
module cmfs_checker import cmfs_pkg::*; #(
    parameter int UV_BITS   = CMFS_UV_BITS
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [2:0]                  m_face_index,
    input logic [UV_BITS-1:0]          m_u_coord,
    input logic [UV_BITS-1:0]          m_v_coord,
    input logic                        m_degenerate
);

    // A zero vector reports zero coordinates.
    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_u_coord == '0 && m_v_coord == '0)
        else $error("degenerate item with nonzero coordinates");

    // A zero vector falls through every compare to the negative Z face.
    a_degenerate_face: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_face_index == FACE_NEG_Z)
        else $error("degenerate item not on the negative Z face");

    a_face_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_face_index <= FACE_NEG_Z)
        else $error("face index out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_face_index) && $stable(m_u_coord)
            && $stable(m_v_coord) && $stable(m_degenerate))
        else $error("stalled result changed");

endmodule

bind cube_map_face_select_unit cmfs_checker #(
    .UV_BITS   (UV_BITS)
) u_cmfs_checker (.*);
